/* rtl/tcbst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blank-synchronised timer package
// Item codes, register selects, mode word bit positions and the request
// bundle that the top level hands to each counter channel.
// ----------------------------------------------------------------------------
package tcbst_pkg;

  localparam int unsigned NumTimers = 3;
  localparam int unsigned CountW    = 16;

  // Item codes; code 3 is unused and does nothing.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  // Register selects; select 3 is unmapped.
  typedef enum logic [1:0] {
    KIND_COUNT  = 2'd0,
    KIND_MODE   = 2'd1,
    KIND_TARGET = 2'd2
  } kind_e;

  // Timer index that selects no counter at all.
  localparam logic [1:0] NoTimer = 2'd3;

  // Sync modes held in mode word bits 2..1.
  localparam logic [1:0] SYNC_MODE0 = 2'd0;
  localparam logic [1:0] SYNC_MODE1 = 2'd1;
  localparam logic [1:0] SYNC_MODE2 = 2'd2;
  localparam logic [1:0] SYNC_MODE3 = 2'd3;

  // Mode word bit positions.
  localparam int unsigned BitSyncEn     = 0;
  localparam int unsigned BitSyncLo     = 1;
  localparam int unsigned BitWrapTarget = 3;
  localparam int unsigned BitHitTarget  = 11;
  localparam int unsigned BitHitMax     = 12;

  localparam logic [CountW-1:0] MaxCount = 16'hFFFF;

  typedef logic [CountW-1:0] word_t;

  // Request from the execute stage to one channel.
  typedef struct packed {
    logic  tick;
    logic  wr;
    kind_e kind;
    word_t data;
    logic  blank;
  } chan_req_t;

endpackage

/* rtl/three_channel_blank_synced_timer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-channel blank-synchronised timer
// Three 16-bit counters with mode words and targets, driven by tick items
// and accessed by register read and write items.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the input channel (in_valid_i / in_stall_o): an item code
//   in mode_i (tick, read or write), the counter in timer_index_i, the
//   register in reg_kind_i, write data and the two blank flags. Every item
//   gives exactly one result transfer on the output channel
//   (out_valid_o / out_stall_i) carrying read_data_o, which is the selected
//   register for a read and zero otherwise.
//   An accepted item is held in an input register; once the result register
//   is free it updates the counter state and loads the result register, so
//   the result is offered from the cycle after the item leaves the input
//   register. One item is taken every cycle while the output side keeps up;
//   this holds because each item applies its state update as it leaves the
//   input register, so each item sees everything the previous one wrote.
//   When the receiver stalls, the result register holds its value, the input
//   register fills, and in_stall_o rises until the result is taken.
//   Reset clears every counter, mode word and target and empties both
//   registers.
// ----------------------------------------------------------------------------
module three_channel_blank_synced_timer_top import tcbst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [1:0]  timer_index_i,
  input  logic [1:0]  reg_kind_i,
  input  logic [15:0] write_data_i,
  input  logic        hblank_i,
  input  logic        vblank_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o
);

  // Input register.
  logic       in_valid_q;
  logic [1:0] op_q;
  logic [1:0] idx_q;
  logic [1:0] kind_q;
  word_t      data_q;
  logic       hb_q;
  logic       vb_q;

  // Result register.
  logic  out_valid_q;
  word_t out_data_q, out_data_d;

  logic out_free;
  logic ex_fire;
  logic in_fire;

  chan_req_t req [NumTimers];
  word_t     cnt [NumTimers];
  word_t     mde [NumTimers];
  word_t     tgt [NumTimers];

  // The result register frees up when empty or when its transfer completes.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ex_fire    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (ex_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= mode_i;
      idx_q  <= timer_index_i;
      kind_q <= reg_kind_i;
      data_q <= write_data_i;
      hb_q   <= hblank_i;
      vb_q   <= vblank_i;
    end
  end

  // Per-channel requests from the item in the input register.
  always_comb begin
    for (int i = 0; i < NumTimers; i++) begin
      req[i].tick  = ex_fire && (op_q == OP_TICK);
      req[i].wr    = ex_fire && (op_q == OP_WRITE) && (idx_q == 2'(i));
      req[i].kind  = kind_e'(kind_q);
      req[i].data  = data_q;
      req[i].blank = 1'b0;
    end
    req[0].blank = hb_q;
    req[1].blank = vb_q;
  end

  tcbst_chan #(.BlankSync(1'b1)) u_chan0 (
    .clk_i, .rst_ni, .req_i(req[0]), .count_o(cnt[0]), .mode_o(mde[0]), .target_o(tgt[0])
  );
  tcbst_chan #(.BlankSync(1'b1)) u_chan1 (
    .clk_i, .rst_ni, .req_i(req[1]), .count_o(cnt[1]), .mode_o(mde[1]), .target_o(tgt[1])
  );
  tcbst_chan #(.BlankSync(1'b0)) u_chan2 (
    .clk_i, .rst_ni, .req_i(req[2]), .count_o(cnt[2]), .mode_o(mde[2]), .target_o(tgt[2])
  );

  // Read path: reads see the state before this item, which reads never change.
  always_comb begin
    out_data_d = '0;
    if (op_q == OP_READ && idx_q != NoTimer) begin
      case (kind_e'(kind_q))
        KIND_COUNT:  out_data_d = cnt[idx_q];
        KIND_MODE:   out_data_d = mde[idx_q];
        KIND_TARGET: out_data_d = tgt[idx_q];
        default:     out_data_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

  // An executed item always produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_fire |=> out_valid_q)
    else $error("executed item produced no result");

  // Backpressure on the input only while an item is waiting in the register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled without a waiting item");

  // Ticks, writes and unused codes return zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_fire && op_q != OP_READ) |=> (read_data_o == '0))
    else $error("non-read item returned non-zero data");

  // Reads of no counter return zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_fire && idx_q == NoTimer) |=> (read_data_o == '0))
    else $error("read of no counter returned non-zero data");

endmodule

/* rtl/tcbst_chan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blank-synchronised timer channel
// Holds one counter with its mode word and target, and applies a tick or a
// register write to them.
// ----------------------------------------------------------------------------
module tcbst_chan import tcbst_pkg::*; #(
  parameter bit BlankSync = 1'b1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  chan_req_t req_i,
  output word_t     count_o,
  output word_t     mode_o,
  output word_t     target_o
);

  word_t count_q, count_d;
  word_t mode_q, mode_d;
  word_t target_q, target_d;

  word_t      tick_mode;
  word_t      base_cnt;
  word_t      stepped;
  logic       inc;
  logic       clr;
  logic [1:0] sync_sel;

  assign sync_sel = mode_q[BitSyncLo +: 2];

  // Count step for a tick, before wrapping.
  always_comb begin
    inc       = 1'b1;
    clr       = 1'b0;
    tick_mode = mode_q;
    if (mode_q[BitSyncEn]) begin
      if (BlankSync) begin
        if (req_i.blank) begin
          if (sync_sel == SYNC_MODE1 || sync_sel == SYNC_MODE2) begin
            clr = 1'b1;
          end
          if (sync_sel == SYNC_MODE3) begin
            tick_mode[BitSyncEn] = 1'b0;
          end
        end else if (sync_sel != SYNC_MODE1) begin
          inc = 1'b0;
        end
      end else if (sync_sel == SYNC_MODE0 || sync_sel == SYNC_MODE3) begin
        inc = 1'b0;
      end
    end
    base_cnt = clr ? '0 : count_q;
    stepped  = inc ? base_cnt + word_t'(1) : base_cnt;
  end

  always_comb begin
    count_d  = count_q;
    mode_d   = mode_q;
    target_d = target_q;
    if (req_i.tick) begin
      count_d = stepped;
      mode_d  = tick_mode;
      if (tick_mode[BitWrapTarget]) begin
        if (stepped >= target_q) begin
          count_d              = '0;
          mode_d[BitHitTarget] = 1'b1;
        end
      end else if (stepped == MaxCount) begin
        count_d           = '0;
        mode_d[BitHitMax] = 1'b1;
      end
    end else if (req_i.wr) begin
      case (req_i.kind)
        KIND_COUNT:  count_d  = '0;
        KIND_MODE:   mode_d   = req_i.data;
        KIND_TARGET: target_d = req_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      mode_q   <= '0;
      target_q <= '0;
    end else begin
      count_q  <= count_d;
      mode_q   <= mode_d;
      target_q <= target_d;
    end
  end

  assign count_o  = count_q;
  assign mode_o   = mode_q;
  assign target_o = target_q;

  // With wrap at 0xFFFF selected, a tick never leaves the count at 0xFFFF.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.tick && !mode_d[BitWrapTarget]) |=> (count_q != MaxCount))
    else $error("count left at 0xFFFF after a tick");

  // With wrap at target selected, a tick never leaves the count at or above
  // the target.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.tick && mode_d[BitWrapTarget]) |=>
      (count_q < target_q || count_q == '0))
    else $error("count left at or above its target after a tick");

endmodule

/* dv/three_channel_blank_synced_timer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the three-channel blank-synchronised timer
// A table of directed items is walked first: reset values, register access
// extremes, each sync mode with the blank flags, the unused item code, the
// unmapped register and the missing counter. A random phase follows, with a
// single long receiver hold-off, and the run ends by reading back every mode
// word and count. Every result transfer is compared with the oldest expected
// read word.
// ----------------------------------------------------------------------------
module three_channel_blank_synced_timer_top_tb;
  import tcbst_pkg::*;

  // Codes that the package leaves without a name.
  localparam logic [1:0] OpUnused     = 2'd3;
  localparam logic [1:0] KindUnmapped = 2'd3;

  localparam int unsigned RandItems = 820;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] idx;
    logic [1:0] kind;
    word_t      data;
    logic       hb;
    logic       vb;
  } timer_item_t;

  // A directed row; when 'typed' is set the expected read word is 'want',
  // otherwise it comes from the timer predictor.
  typedef struct packed {
    timer_item_t it;
    logic        typed;
    word_t       want;
  } dir_row_t;

  localparam int unsigned DirRows = 27;
  localparam dir_row_t DirTab [DirRows] = '{
    // Everything reads as zero straight after reset.
    '{'{OP_READ,  2'd0,    KIND_COUNT,   16'h0000, 1'b0, 1'b0}, 1'b1, 16'h0000},
    '{'{OP_READ,  2'd2,    KIND_TARGET,  16'h0000, 1'b0, 1'b0}, 1'b1, 16'h0000},
    '{'{OP_READ,  NoTimer, KIND_MODE,    16'hFFFF, 1'b1, 1'b1}, 1'b1, 16'h0000},
    // Mode word stores all ones and all zeroes unchanged.
    '{'{OP_WRITE, 2'd1,    KIND_MODE,    16'hFFFF, 1'b0, 1'b0}, 1'b1, 16'h0000},
    '{'{OP_READ,  2'd1,    KIND_MODE,    16'h0000, 1'b0, 1'b0}, 1'b1, 16'hFFFF},
    '{'{OP_WRITE, 2'd1,    KIND_MODE,    16'h0000, 1'b0, 1'b0}, 1'b1, 16'h0000},
    // Counter 0 wraps at a target of two and sets the target hit bit.
    '{'{OP_WRITE, 2'd0,    KIND_TARGET,  16'h0002, 1'b0, 1'b0}, 1'b1, 16'h0000},
    '{'{OP_WRITE, 2'd0,    KIND_MODE,    16'h0008, 1'b0, 1'b0}, 1'b1, 16'h0000},
    '{'{OP_TICK,  2'd0,    KIND_COUNT,   16'h0000, 1'b1, 1'b1}, 1'b1, 16'h0000},
    '{'{OP_TICK,  2'd0,    KIND_COUNT,   16'h0000, 1'b0, 1'b0}, 1'b1, 16'h0000},
    '{'{OP_READ,  2'd0,    KIND_MODE,    16'h0000, 1'b0, 1'b0}, 1'b1, 16'h0808},
    '{'{OP_READ,  2'd1,    KIND_COUNT,   16'h0000, 1'b0, 1'b0}, 1'b0, 16'h0000},
    // Sync mode 1 on counter 0: blank clears, no blank still counts.
    '{'{OP_WRITE, 2'd0,    KIND_MODE,    16'h0003, 1'b0, 1'b0}, 1'b0, 16'h0000},
    '{'{OP_TICK,  2'd0,    KIND_COUNT,   16'h0000, 1'b1, 1'b0}, 1'b0, 16'h0000},
    '{'{OP_TICK,  2'd0,    KIND_COUNT,   16'h0000, 1'b0, 1'b1}, 1'b0, 16'h0000},
    // Sync mode 3: hold outside blank, blank drops the sync enable bit.
    '{'{OP_WRITE, 2'd0,    KIND_MODE,    16'h0007, 1'b0, 1'b0}, 1'b0, 16'h0000},
    '{'{OP_TICK,  2'd0,    KIND_COUNT,   16'h0000, 1'b0, 1'b0}, 1'b0, 16'h0000},
    '{'{OP_TICK,  2'd0,    KIND_COUNT,   16'h0000, 1'b1, 1'b0}, 1'b0, 16'h0000},
    '{'{OP_READ,  2'd0,    KIND_MODE,    16'h0000, 1'b0, 1'b0}, 1'b0, 16'h0000},
    // Counter 2 pauses in sync mode 0; counter 1 in sync mode 2 on vblank.
    '{'{OP_WRITE, 2'd2,    KIND_MODE,    16'h0001, 1'b0, 1'b0}, 1'b0, 16'h0000},
    '{'{OP_WRITE, 2'd1,    KIND_MODE,    16'h0005, 1'b0, 1'b0}, 1'b0, 16'h0000},
    '{'{OP_TICK,  2'd0,    KIND_COUNT,   16'h0000, 1'b0, 1'b1}, 1'b0, 16'h0000},
    '{'{OP_READ,  2'd2,    KIND_COUNT,   16'h0000, 1'b0, 1'b0}, 1'b0, 16'h0000},
    // A count write clears regardless of data; unmapped and unused do nothing.
    '{'{OP_WRITE, 2'd2,    KIND_COUNT,   16'hFFFF, 1'b0, 1'b0}, 1'b1, 16'h0000},
    '{'{OP_WRITE, 2'd0,    KindUnmapped, 16'hFFFF, 1'b1, 1'b1}, 1'b1, 16'h0000},
    '{'{OP_READ,  2'd0,    KindUnmapped, 16'h0000, 1'b0, 1'b0}, 1'b1, 16'h0000},
    '{'{OpUnused, NoTimer, KindUnmapped, 16'hFFFF, 1'b1, 1'b1}, 1'b1, 16'h0000}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i        = '0;
  logic [1:0]  timer_index_i = '0;
  logic [1:0]  reg_kind_i    = '0;
  logic [15:0] write_data_i  = '0;
  logic        hblank_i      = 1'b0;
  logic        vblank_i      = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [15:0] read_data_o;

  three_channel_blank_synced_timer_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .timer_index_i,
    .reg_kind_i,
    .write_data_i,
    .hblank_i,
    .vblank_i,
    .out_valid_o,
    .out_stall_i,
    .read_data_o
  );

  // The predictor's own copy of the counter state.
  word_t count_q  [NumTimers];
  word_t modew_q  [NumTimers];
  word_t target_q [NumTimers];

  // Read words still owed by the block, oldest first.
  word_t read_data_q [$];

  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  bit          hold_req   = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Generous wall for the whole run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: %s", $time, what);
  endtask

  // Blank-synchronised counting for counters 0 and 1.
  function automatic void count_on_blank(input int t, input logic blank);
    logic [1:0] sm;
    sm = modew_q[t][BitSyncLo +: 2];
    if (modew_q[t][BitSyncEn]) begin
      if (blank) begin
        if (sm == SYNC_MODE1 || sm == SYNC_MODE2) begin
          count_q[t] = '0;
        end
        if (sm == SYNC_MODE3) begin
          modew_q[t][BitSyncEn] = 1'b0;
        end
      end else if (sm != SYNC_MODE1) begin
        return;
      end
    end
    count_q[t] = count_q[t] + 16'd1;
  endfunction

  function automatic void wrap_counter(input int t);
    if (modew_q[t][BitWrapTarget]) begin
      if (count_q[t] >= target_q[t]) begin
        count_q[t] = '0;
        modew_q[t][BitHitTarget] = 1'b1;
      end
    end else if (count_q[t] >= MaxCount) begin
      count_q[t] = '0;
      modew_q[t][BitHitMax] = 1'b1;
    end
  endfunction

  // Applies one accepted item to the predicted state and returns the read word.
  function automatic word_t advance_timers(input timer_item_t it);
    word_t      rd;
    logic [1:0] sm;
    rd = '0;
    if (it.op == OP_TICK) begin
      count_on_blank(0, it.hb);
      wrap_counter(0);
      count_on_blank(1, it.vb);
      wrap_counter(1);
      sm = modew_q[2][BitSyncLo +: 2];
      if (!(modew_q[2][BitSyncEn] && (sm == SYNC_MODE0 || sm == SYNC_MODE3))) begin
        count_q[2] = count_q[2] + 16'd1;
      end
      wrap_counter(2);
    end else if (it.idx != NoTimer) begin
      if (it.op == OP_READ) begin
        case (it.kind)
          KIND_COUNT:  rd = count_q[it.idx];
          KIND_MODE:   rd = modew_q[it.idx];
          KIND_TARGET: rd = target_q[it.idx];
          default:     rd = '0;
        endcase
      end else if (it.op == OP_WRITE) begin
        case (it.kind)
          KIND_COUNT:  count_q[it.idx] = '0;
          KIND_MODE:   modew_q[it.idx] = it.data;
          KIND_TARGET: target_q[it.idx] = it.data;
          default:     ;
        endcase
      end
    end
    return rd;
  endfunction

  // Offers one item and waits for its transfer. The sender works in bursts;
  // when a burst runs out, valid drops for a random gap, so valid is never
  // lowered and raised within the same time step.
  task automatic send_item(input timer_item_t it, input logic typed, input word_t want);
    word_t predicted;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    mode_i        <= it.op;
    timer_index_i <= it.idx;
    reg_kind_i    <= it.kind;
    write_data_i  <= it.data;
    hblank_i      <= it.hb;
    vblank_i      <= it.vb;
    // Signals read just after the edge still hold their pre-edge values.
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = advance_timers(it);
    read_data_q.push_back(typed ? want : predicted);
  endtask

  // Receiver: stall patterns change at random segment boundaries, and on request a
  // long hold-off is counted out here so that the block fills and stalls.
  initial begin : stall_gen
    int unsigned style;
    int unsigned seg_left;
    int unsigned hold_left;
    style     = 0;
    seg_left  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_left == 0) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (seg_left == 0) begin
        style    = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 120);
      end
      seg_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (style)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  // Result monitor: each transfer is checked against the oldest owed word.
  initial begin : result_check
    word_t owed;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (read_data_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result transfer, read_data %h",
                                    read_data_o));
        end else begin
          owed = read_data_q.pop_front();
          if (read_data_o !== owed) begin
            report_mismatch($sformatf("read_data %h, expected %h", read_data_o, owed));
          end
        end
      end
    end
  end

  initial begin : stimulus
    timer_item_t it;
    int unsigned pick;
    int unsigned iter;
    int unsigned settle;

    for (int t = 0; t < NumTimers; t++) begin
      count_q[t]  = '0;
      modew_q[t]  = '0;
      target_q[t] = '0;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int r = 0; r < DirRows; r++) begin
      send_item(DirTab[r].it, DirTab[r].typed, DirTab[r].want);
    end

    // Random phase: mostly ticks and real register accesses, with targets
    // kept small so that wraps at target happen often.
    iter = 0;
    while (iter < RandItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        it.op = OP_TICK;
      end else if (pick < 72) begin
        it.op = OP_READ;
      end else if (pick < 95) begin
        it.op = OP_WRITE;
      end else begin
        it.op = OpUnused;
      end
      it.idx  = ($urandom_range(0, 9) == 0) ? NoTimer : 2'($urandom_range(0, 2));
      it.kind = ($urandom_range(0, 9) == 0) ? KindUnmapped : 2'($urandom_range(0, 2));
      it.data = 16'($urandom);
      if (it.op == OP_WRITE && it.kind == KIND_TARGET && $urandom_range(0, 3) != 0) begin
        it.data = 16'($urandom_range(0, 40));
      end
      it.hb = 1'($urandom_range(0, 1));
      it.vb = 1'($urandom_range(0, 1));
      // One long receiver hold-off in the middle of the random phase.
      if (iter == RandItems / 2) begin
        hold_req = 1'b1;
      end
      iter++;
      send_item(it, 1'b0, '0);
    end

    // Read back every mode word and count.
    for (int t = 0; t < NumTimers; t++) begin
      it = '{OP_READ, 2'(t), KIND_MODE, 16'h0000, 1'b0, 1'b0};
      send_item(it, 1'b0, '0);
      it.kind = KIND_COUNT;
      send_item(it, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // Drain every owed result, then give any stray extra result time to show.
    while (read_data_q.size() != 0) @(posedge clk_i);
    settle = 20;
    repeat (settle) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
